### rtl/core/blrp_pkg.sv
// ============================================================================
// Buoy report line parser package
// Shared item types and sizing constants.
// ============================================================================
`default_nettype none

package blrp_pkg;

   localparam int LINE_BYTES  = 256;
   localparam int MAX_TOKENS  = 24;
   localparam int VALUE_BITS  = 24;
   localparam int MIN_TOKENS  = 15;
   localparam int NUM_RESULTS = 11;
   localparam int NUM_INT     = 5;

   localparam int LEN_W  = $clog2(LINE_BYTES);
   localparam int CNT_W  = $clog2(MAX_TOKENS + 1);
   localparam int SLOT_W = $clog2(NUM_RESULTS);
   localparam int MAG_W  = VALUE_BITS - 1;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [3:0]                   field_id;
      logic signed [VALUE_BITS-1:0] field_value;
      logic                         value_valid;
      logic                         record_found;
      logic                         last_result;
   } rsp_type;

   // One finished report: either a found record with its kept values or a
   // not-found marker.
   typedef struct packed {
      logic                                   found;
      logic [NUM_RESULTS-1:0]                 valid;
      logic [NUM_RESULTS-1:0][VALUE_BITS-1:0] values;
   } rec_type;

endpackage

`default_nettype wire

### rtl/core/blrp_front.sv
// ============================================================================
// Buoy report line parser front end
// Takes one byte per cycle unless req_full; tokenizes lines, keeps record fields.
// ============================================================================
`default_nettype none

module blrp_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire blrp_pkg::req_type req_item,
   output logic                  q_push,
   output blrp_pkg::rec_type     q_data,
   input  wire logic             q_full
);
   import blrp_pkg::*;

   localparam int WIDE_W = MAG_W + 8;
   localparam logic [WIDE_W-1:0] LIM_W = WIDE_W'(1) << MAG_W;

   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_SP   = 8'h20;
   localparam logic [7:0] CH_TAB  = 8'h09;
   localparam logic [7:0] CH_PLUS = 8'h2B;
   localparam logic [7:0] CH_MIN  = 8'h2D;
   localparam logic [7:0] CH_DOT  = 8'h2E;
   localparam logic [7:0] CH_0    = 8'h30;
   localparam logic [7:0] CH_9    = 8'h39;
   localparam logic [7:0] CH_M    = 8'h4D;

   localparam logic [1:0] PH_LEAD = 2'd0;
   localparam logic [1:0] PH_INT  = 2'd1;
   localparam logic [1:0] PH_FRAC = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;

   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] int_acc;
      logic             int_big;
      logic [MAG_W-1:0] hund_acc;
      logic             hund_big;
      logic [1:0]       phase;
      logic [1:0]       fdig;
      logic             flags;
      logic [2:0]       chars;
      logic [2:0]       marker;
   } tok_type;

   localparam tok_type TOK_FRESH = '{neg: 1'b0, int_acc: '0, int_big: 1'b0,
                                     hund_acc: '0, hund_big: 1'b0, phase: PH_LEAD,
                                     fdig: 2'd0, flags: 1'b0, chars: 3'd0,
                                     marker: 3'b111};

   // Character of marker "MM", "99.00" or "999" at a position, zero past its end.
   function automatic logic [7:0] marker_char(input logic [1:0] idx, input logic [2:0] pos);
      logic [7:0] r;
      r = 8'h00;
      case (idx)
         2'd0: if (pos < 3'd2) r = CH_M;
         2'd1: begin
            case (pos)
               3'd0, 3'd1: r = CH_9;
               3'd2:       r = CH_DOT;
               3'd3, 3'd4: r = CH_0;
               default:    r = 8'h00;
            endcase
         end
         2'd2: if (pos < 3'd3) r = CH_9;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic slot_hit(input logic [CNT_W-1:0] t);
      return (t <= CNT_W'(6)) || (t == CNT_W'(8)) || (t == CNT_W'(9)) ||
             (t == CNT_W'(11)) || (t == CNT_W'(14));
   endfunction

   function automatic logic [SLOT_W-1:0] slot_id(input logic [CNT_W-1:0] t);
      logic [SLOT_W-1:0] r;
      case (t)
         CNT_W'(8):  r = SLOT_W'(7);
         CNT_W'(9):  r = SLOT_W'(8);
         CNT_W'(11): r = SLOT_W'(9);
         CNT_W'(14): r = SLOT_W'(10);
         default:    r = SLOT_W'(t);
      endcase
      return r;
   endfunction

   function automatic logic [VALUE_BITS-1:0] saturate(input logic neg, input logic big,
                                                     input logic [MAG_W-1:0] mag);
      logic [VALUE_BITS-1:0] r;
      if (big) begin
         r = neg ? {1'b1, {MAG_W{1'b0}}} : {1'b0, {MAG_W{1'b1}}};
      end else begin
         r = neg ? -{1'b0, mag} : {1'b0, mag};
      end
      return r;
   endfunction

   function automatic tok_type feed(input tok_type s, input logic [7:0] c);
      tok_type          r;
      logic             dig;
      logic [WIDE_W-1:0] d;
      logic [WIDE_W-1:0] wi;
      logic [WIDE_W-1:0] wh;
      logic             int_step;
      logic             frac_step;
      r = s;
      dig = (c >= CH_0) && (c <= CH_9);
      d = WIDE_W'(c[3:0]);
      int_step = 1'b0;
      frac_step = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (marker_char(2'(i), s.chars) != c) r.marker[i] = 1'b0;
      end
      if (s.chars < 3'd6) r.chars = s.chars + 3'd1;
      case (s.phase)
         PH_LEAD: begin
            if (c == CH_SP || (c >= 8'd9 && c <= 8'd13)) begin
               r.phase = PH_LEAD;
            end else if (c == CH_PLUS) begin
               r.phase = PH_INT;
            end else if (c == CH_MIN) begin
               r.neg = 1'b1;
               r.phase = PH_INT;
            end else if (c == CH_DOT) begin
               r.phase = PH_FRAC;
            end else if (!dig) begin
               r.phase = PH_DONE;
            end else begin
               r.phase = PH_INT;
               int_step = 1'b1;
            end
         end
         PH_INT: begin
            if (dig) int_step = 1'b1;
            else if (c == CH_DOT) r.phase = PH_FRAC;
            else r.phase = PH_DONE;
         end
         PH_FRAC: begin
            if (dig) frac_step = 1'b1;
            else r.phase = PH_DONE;
         end
         default: r.phase = PH_DONE;
      endcase
      wi = {{(WIDE_W-MAG_W){1'b0}}, s.int_acc} * WIDE_W'(10) + d;
      wh = {{(WIDE_W-MAG_W){1'b0}}, s.hund_acc} * WIDE_W'(10) + d * WIDE_W'(100);
      if (frac_step) begin
         wh = {{(WIDE_W-MAG_W){1'b0}}, s.hund_acc} +
              ((s.fdig == 2'd0) ? d * WIDE_W'(10) : d);
      end
      if (int_step) begin
         r.flags = 1'b1;
         if (!s.int_big) begin
            if (wi >= LIM_W) r.int_big = 1'b1;
            else r.int_acc = wi[MAG_W-1:0];
         end
      end
      if (frac_step) r.flags = 1'b1;
      if (int_step || (frac_step && s.fdig < 2'd2)) begin
         if (frac_step) r.fdig = s.fdig + 2'd1;
         if (!s.hund_big) begin
            if (wh >= LIM_W) r.hund_big = 1'b1;
            else r.hund_acc = wh[MAG_W-1:0];
         end
      end
      return r;
   endfunction

   logic                                   header_ff, rdone_ff, stopped_ff, lhdr_ff, intok_ff;
   logic [LEN_W-1:0]                       len_ff;
   logic [CNT_W-1:0]                       cnt_ff;
   tok_type                                tok_ff;
   logic [NUM_RESULTS-1:0]                 kvalid_ff;
   logic [NUM_RESULTS-1:0][VALUE_BITS-1:0] kept_ff;

   logic                                   accept, eot, active, take, judge, hash_first;
   logic                                   header1, lhdr1, room, tokenize, sep, cr;
   logic                                   intok1, tok_close, close_now, commit, marker;
   logic [7:0]                             c;
   tok_type                                tok1;
   logic [CNT_W-1:0]                       cnt1, tidx;
   logic [SLOT_W-1:0]                      slot;
   logic [VALUE_BITS-1:0]                  val;
   logic                                   vld;
   logic [NUM_RESULTS-1:0]                 kvalid_in;
   logic [NUM_RESULTS-1:0][VALUE_BITS-1:0] kept_in;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign c        = req_item.text_byte;
   assign eot      = req_item.end_of_text;

   always_comb begin
      active     = accept && !rdone_ff && !stopped_ff;
      take       = active && (c != 8'h00) && (c != CH_LF);
      judge      = active && ((c == 8'h00) || (c == CH_LF) || eot);
      hash_first = take && (len_ff == '0) && (c == CH_HASH);
      header1    = header_ff || hash_first;
      lhdr1      = lhdr_ff || hash_first;
      room       = len_ff < LEN_W'(LINE_BYTES - 1);
      tokenize   = take && room && header1 && !lhdr1;
      sep        = (c == CH_SP) || (c == CH_TAB);
      cr         = (c == CH_CR);

      tok1      = tok_ff;
      intok1    = intok_ff;
      cnt1      = cnt_ff;
      tok_close = 1'b0;
      if (tokenize) begin
         if (!intok_ff) begin
            if (!sep && cnt_ff < CNT_W'(MAX_TOKENS)) begin
               cnt1   = cnt_ff + CNT_W'(1);
               intok1 = 1'b1;
               if (cr) begin
                  tok1      = TOK_FRESH;
                  tok_close = 1'b1;
               end else begin
                  tok1 = feed(TOK_FRESH, c);
               end
            end
         end else if (sep || cr) begin
            tok_close = 1'b1;
         end else begin
            tok1 = feed(tok_ff, c);
         end
      end

      close_now = intok1 && (tok_close || judge);
      tidx      = cnt1 - CNT_W'(1);
      slot      = slot_id(tidx);
      marker    = (tok1.marker[0] && tok1.chars == 3'd2) ||
                  (tok1.marker[1] && tok1.chars == 3'd5) ||
                  (tok1.marker[2] && tok1.chars == 3'd3);
      if (slot < SLOT_W'(NUM_INT)) begin
         vld = 1'b1;
         val = saturate(tok1.neg, tok1.int_big, tok1.int_acc);
      end else begin
         vld = tok1.flags && !marker;
         val = vld ? saturate(tok1.neg, tok1.hund_big, tok1.hund_acc) : '0;
      end

      kept_in   = kept_ff;
      kvalid_in = kvalid_ff;
      if (close_now && slot_hit(tidx)) begin
         kept_in[slot]   = val;
         kvalid_in[slot] = vld;
      end

      commit        = judge && header1 && !lhdr1 && (cnt1 >= CNT_W'(MIN_TOKENS));
      q_push        = commit || (accept && eot && !rdone_ff);
      q_data.found  = commit;
      q_data.valid  = kvalid_in;
      q_data.values = kept_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && eot)) begin
         header_ff  <= 1'b0;
         rdone_ff   <= 1'b0;
         stopped_ff <= 1'b0;
         lhdr_ff    <= 1'b0;
         intok_ff   <= 1'b0;
         len_ff     <= '0;
         cnt_ff     <= '0;
         kvalid_ff  <= '0;
      end else if (active) begin
         if (judge) begin
            rdone_ff   <= commit;
            stopped_ff <= (c == 8'h00);
            lhdr_ff    <= 1'b0;
            intok_ff   <= 1'b0;
            len_ff     <= '0;
            cnt_ff     <= '0;
            kvalid_ff  <= '0;
         end else begin
            header_ff <= header1;
            lhdr_ff   <= lhdr1;
            if (take && room) len_ff <= len_ff + LEN_W'(1);
            cnt_ff    <= cnt1;
            intok_ff  <= intok1 && !tok_close;
            kvalid_ff <= kvalid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (active) begin
         tok_ff  <= tok1;
         kept_ff <= kept_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/blrp_queue.sv
// ============================================================================
// Buoy report line parser report queue
// Two-entry queue of finished reports between front and back ends.
// ============================================================================
`default_nettype none

module blrp_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire blrp_pkg::rec_type push_data,
   output logic                  full,
   input  wire logic             pop,
   output blrp_pkg::rec_type     head,
   output logic                  empty
);
   import blrp_pkg::*;

   rec_type    ent_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic       do_push, do_pop;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign head    = ent_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (do_push) wr_ff <= !wr_ff;
         if (do_pop) rd_ff <= !rd_ff;
         if (do_push && !do_pop) cnt_ff <= cnt_ff + 2'd1;
         else if (do_pop && !do_push) cnt_ff <= cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) ent_ff[wr_ff] <= push_data;
   end

endmodule

`default_nettype wire

### rtl/core/blrp_back.sv
// ============================================================================
// Buoy report line parser back end
// Turns one finished report into its result items through an output register.
// ============================================================================
`default_nettype none

module blrp_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire blrp_pkg::rec_type q_head,
   input  wire logic             q_empty,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output blrp_pkg::rsp_type     rsp_item
);
   import blrp_pkg::*;

   rec_type           cur_ff;
   logic              busy_ff, out_valid_ff;
   logic [3:0]        idx_ff;
   rsp_type           out_ff;
   logic              advance, last;
   rsp_type           item;
   logic [SLOT_W-1:0] sel;

   assign rsp_empty = !out_valid_ff;
   assign rsp_item  = out_ff;
   assign advance   = !out_valid_ff || rsp_pop;
   // The next report is picked up in the cycle that hands out the last item of
   // the current one, so consecutive reports leave no gap between items.
   assign q_pop     = !q_empty && (!busy_ff || (advance && last));
   assign sel       = SLOT_W'(idx_ff);

   always_comb begin
      last              = !cur_ff.found || (idx_ff == 4'(NUM_RESULTS - 1));
      item.field_id     = cur_ff.found ? idx_ff : 4'd0;
      item.field_value  = cur_ff.found ? cur_ff.values[sel] : '0;
      item.value_valid  = cur_ff.found && cur_ff.valid[sel];
      item.record_found = cur_ff.found;
      item.last_result  = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff       <= 4'd0;
      end else begin
         if (busy_ff && advance) begin
            out_valid_ff <= 1'b1;
            if (last) busy_ff <= 1'b0;
            else idx_ff <= idx_ff + 4'd1;
         end else if (advance) begin
            out_valid_ff <= 1'b0;
         end
         if (q_pop) begin
            busy_ff <= 1'b1;
            idx_ff  <= 4'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) cur_ff <= q_head;
      if (busy_ff && advance) out_ff <= item;
   end

endmodule

`default_nettype wire

### rtl/core/buoy_report_line_parser.sv
// ============================================================================
// Buoy report line parser
// Finds the first full data line after a header in a buoy text report and
// returns its date, time and six measurements as result items.
// ============================================================================
//
//   Channel   Ports                          Moves
//   --------  -----------------------------  ---------------------------------
//   input     req_push, req_full, req_item   one report byte per item
//   result    rsp_empty, rsp_pop, rsp_item   one field per item, 11 or 1/run
//
// The input side takes one byte every cycle while req_full is low; the parser
// keeps all of its line and token state in registers updated once per byte.
// A finished report (eleven fields, or a single not-found item) goes into a
// two-entry queue; the back end drains it at one result item per cycle while
// results are taken, through the queue entry, report and output registers.
// req_full rises only when both queue entries hold reports still waiting.
// Reset is synchronous and clears all control state; there is no sweep.
//
`default_nettype none

module buoy_report_line_parser (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire blrp_pkg::req_type req_item,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output blrp_pkg::rsp_type     rsp_item
);
   import blrp_pkg::*;

   // Reports handed from the byte parser to the result sequencer.
   logic    q_push, q_full, q_pop, q_empty;
   rec_type q_data, q_head;

   // The front end parses bytes and closes a report on a record line or at the
   // end of the text.
   blrp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_item (req_item),
      .q_push   (q_push),
      .q_data   (q_data),
      .q_full   (q_full)
   );

   blrp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   // The back end walks the kept fields of one report in order.
   blrp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (q_head),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

### rtl/core/blrp_checker.sv
// ============================================================================
// Buoy report line parser checker
// Port-level checks on the result channel, bound to the top level.
// ============================================================================
`default_nettype none

module blrp_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_empty,
   input wire logic             rsp_pop,
   input wire blrp_pkg::rsp_type rsp_item
);

   // Nothing is offered right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result offered right after reset");

   // A result that is not taken stays put.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_item)))
      else $error("waiting result changed");

   // A not-found result is the only and last item of its run.
   a_not_found: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_item.record_found) |->
      (rsp_item.last_result && rsp_item.field_id == 4'd0 && !rsp_item.value_valid))
      else $error("malformed not-found result");

   // A record ends on the water temperature field.
   a_record_end: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_item.record_found && rsp_item.last_result) |->
      (rsp_item.field_id == 4'd10))
      else $error("record ended early");

   // Date and time fields of a record are always present.
   a_date_valid: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_item.record_found && rsp_item.field_id <= 4'd4) |->
      rsp_item.value_valid)
      else $error("date field marked missing");

endmodule

bind buoy_report_line_parser blrp_checker u_blrp_checker (.*);

`default_nettype wire
